### design/u8js_pkg.sv
package u8js_pkg;

	localparam int COUNT_BITS = 16;
	localparam int CFG_W      = 16;
	localparam int CNT_W      = COUNT_BITS;
	localparam int ROOM_W     = CNT_W + 1;
	localparam int WIDE_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam logic [WIDE_W-1:0] CNT_CAP = WIDE_W'({CNT_W{1'b1}});

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_MAX_KEPT = '0;
	localparam logic [CFG_W-1:0] MAX_KEPT_RST = 16'd256;

	localparam int TQ_DEPTH = 4;
	localparam int TQ_AW    = 2;

	// sequence classifier codes; values 1 to 4 are the valid lengths
	localparam logic [2:0] SQ_BAD  = 3'd0;
	localparam logic [2:0] SQ_ONE  = 3'd1;
	localparam logic [2:0] SQ_WAIT = 3'd5;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] REPL_B0   = 8'hEF;
	localparam logic [7:0] REPL_B1   = 8'hBF;
	localparam logic [7:0] REPL_B2   = 8'hBD;

	typedef struct packed {
		logic       cmd;
		logic [7:0] text_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_done;
		logic       was_cut;
	} result_t;

	typedef logic [3:0][7:0] quad_t;

	typedef enum logic [2:0] {
		TK_OPEN,
		TK_CLOSE,
		TK_CHAR,
		TK_REPL,
		TK_SEQ
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t  kind;
		quad_t      data;
		logic [2:0] len;
		logic       last;
		logic       cut;
	} tok_t;

	typedef struct packed {
		logic             wr;
		logic [CNT_W-1:0] lim;
	} cfg_t;

	function automatic logic [CNT_W-1:0] sat_limit(input logic [CFG_W-1:0] v);
		logic [WIDE_W-1:0] ext;
		logic [WIDE_W-1:0] sat;
		ext = WIDE_W'(v);
		sat = (ext > CNT_CAP) ? CNT_CAP : ext;
		return sat[CNT_W-1:0];
	endfunction

	// classify the sequence at b[0] given n bytes present
	function automatic logic [2:0] seq_len(input quad_t b, input logic [2:0] n,
		input logic at_end);
		logic [7:0] lead;
		logic [7:0] c;
		logic [2:0] need;
		logic [2:0] res;
		logic       stop;
		lead = b[0];
		need = 3'd0;
		res  = SQ_BAD;
		stop = 1'b0;
		if (lead < 8'h80) begin
			res  = SQ_ONE;
			stop = 1'b1;
		end else if (lead >= 8'hC2 && lead <= 8'hDF) begin
			need = 3'd2;
		end else if (lead >= 8'hE0 && lead <= 8'hEF) begin
			need = 3'd3;
		end else if (lead >= 8'hF0 && lead <= 8'hF4) begin
			need = 3'd4;
		end else begin
			stop = 1'b1;
		end
		if (!stop)
			res = need;
		for (int i = 1; i < 4; i++) begin
			c = b[i];
			if (!stop && 3'(i) < need) begin
				if (3'(i) >= n) begin
					res  = at_end ? SQ_BAD : SQ_WAIT;
					stop = 1'b1;
				end else if ((c & 8'hC0) != 8'h80) begin
					res  = SQ_BAD;
					stop = 1'b1;
				end else if (i == 1 && ((lead == 8'hE0 && c < 8'hA0) ||
					(lead == 8'hED && c > 8'h9F) || (lead == 8'hF0 && c < 8'h90) ||
					(lead == 8'hF4 && c > 8'h8F))) begin
					res  = SQ_BAD;
					stop = 1'b1;
				end
			end
		end
		return res;
	endfunction

	// kept-byte cost of a decided character
	function automatic logic [3:0] seq_cost(input logic [2:0] code);
		return (code == SQ_BAD) ? 4'd3 : {1'b0, code};
	endfunction

	function automatic logic [7:0] char_esc(input logic [7:0] c);
		logic [7:0] e;
		case (c)
			8'h22:   e = 8'h22;
			8'h5C:   e = 8'h5C;
			8'h0A:   e = 8'h6E;
			8'h0D:   e = 8'h72;
			8'h09:   e = 8'h74;
			8'h08:   e = 8'h62;
			8'h0C:   e = 8'h66;
			default: e = 8'h00;
		endcase
		return e;
	endfunction

	function automatic logic [2:0] char_len(input logic [7:0] c);
		logic [2:0] l;
		if (char_esc(c) != 8'h00)
			l = 3'd2;
		else if (c < 8'h20)
			l = 3'd6;
		else
			l = 3'd1;
		return l;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h57 + {4'h0, v});
	endfunction

	function automatic logic [2:0] tok_len(input tok_t t);
		logic [2:0] l;
		case (t.kind) inside
			TK_OPEN, TK_CLOSE: l = 3'd1;
			TK_REPL:           l = 3'd3;
			TK_SEQ:            l = t.len;
			TK_CHAR:           l = char_len(t.data[0]);
			default:           l = 3'd1;
		endcase
		return l;
	endfunction

	function automatic logic [7:0] tok_byte(input tok_t t, input logic [2:0] idx);
		logic [7:0] c;
		logic [7:0] e;
		logic [7:0] b;
		c = t.data[0];
		e = char_esc(c);
		case (t.kind) inside
			TK_OPEN, TK_CLOSE: b = CH_QUOTE;
			TK_REPL: begin
				if (idx == 3'd0)
					b = REPL_B0;
				else if (idx == 3'd1)
					b = REPL_B1;
				else
					b = REPL_B2;
			end
			TK_SEQ: b = t.data[idx[1:0]];
			TK_CHAR: begin
				if (char_len(c) == 3'd1) begin
					b = c;
				end else begin
					case (idx) inside
						3'd0:       b = CH_BSLASH;
						3'd1:       b = (e != 8'h00) ? e : CH_U;
						3'd2, 3'd3: b = CH_ZERO;
						3'd4:       b = hex_digit(c[7:4]);
						default:    b = hex_digit(c[3:0]);
					endcase
				end
			end
			default: b = CH_QUOTE;
		endcase
		return b;
	endfunction

endpackage

### design/utf8_sanitize_json_string_escape.sv
// Streams raw text bytes into a quoted JSON string with UTF-8 checking and a
// kept-byte cap. Push one item per beat: cmd 0 carries a text byte, cmd 1 ends
// the string and yields the closing quote (string_done, with was_cut if the cap
// cut the string). Pop output bytes; run_last marks the last byte an item caused,
// and an item that only extends an unfinished sequence or is dropped after a cut
// yields none. The front decides one token per cycle while the token queue has room
// (opening quote, one character, one U+FFFD, closing quote). Tokens pass a
// four-entry queue to the back, which drives one output byte per cycle while the
// consumer pops: a token gives one byte per plain or UTF-8 byte, two or six for an
// escape, three for U+FFFD. The back's one byte per cycle sets the sustained rate.
// max_kept_bytes sits at APB address 0 (reset 256); write it only while no item is
// in flight.
module utf8_sanitize_json_string_escape import u8js_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  item_t              item,
	output logic               empty,
	input  logic               pop,
	output result_t            result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [CFG_W-1:0] max_q;
	logic             reg_hit;
	cfg_t             cfg;
	logic [CNT_W-1:0] lim;
	logic             tq_push;
	tok_t             tq_wtok;
	logic             tq_full;
	tok_t             tq_rtok;
	logic             tq_empty;
	logic             tq_pop;

	assign pready  = 1'b1;
	assign reg_hit = paddr[PADDR_W-1:2] == REG_MAX_KEPT;
	assign cfg.wr  = psel && penable && pwrite && pready && reg_hit;
	assign cfg.lim = sat_limit(pwdata[CFG_W-1:0]);
	assign lim     = sat_limit(max_q);
	assign prdata  = reg_hit ? PDATA_W'(max_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_q <= MAX_KEPT_RST;
		else if (cfg.wr)
			max_q <= pwdata[CFG_W-1:0];
	end

	u8js_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.cfg     (cfg),
		.lim     (lim),
		.tq_push (tq_push),
		.tq_tok  (tq_wtok),
		.tq_full (tq_full)
	);

	u8js_tq u_tq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (tq_push),
		.wtok   (tq_wtok),
		.full   (tq_full),
		.pop    (tq_pop),
		.rtok   (tq_rtok),
		.empty  (tq_empty)
	);

	u8js_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok      (tq_rtok),
		.tq_empty (tq_empty),
		.tq_pop   (tq_pop),
		.result   (result),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

### design/u8js_tq.sv
module u8js_tq import u8js_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tok_t wtok,
	output logic full,
	input  logic pop,
	output tok_t rtok,
	output logic empty
);

	tok_t             mem_q [TQ_DEPTH];
	logic [TQ_AW-1:0] wp_q;
	logic [TQ_AW-1:0] rp_q;
	logic [TQ_AW:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = cnt_q == (TQ_AW+1)'(TQ_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rtok    = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wp_q <= wp_q + 1'b1;
			if (do_pop)
				rp_q <= rp_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wp_q] <= wtok;
	end

endmodule

### design/u8js_front.sv
module u8js_front import u8js_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  item_t            item,
	input  cfg_t             cfg,
	input  logic [CNT_W-1:0] lim,
	output logic             tq_push,
	output tok_t             tq_tok,
	input  logic             tq_full
);

	logic                     itm_v_q;
	item_t                    itm_q;
	logic                     ld_q;
	quad_t                    w_q;
	logic [2:0]               n_q;
	logic                     opened_q;
	logic                     cut_q;
	logic [CNT_W-1:0]         kept_q;
	logic signed [ROOM_W-1:0] room_q;

	logic       ending;
	quad_t      w_e;
	logic [2:0] n_e;
	logic [2:0] sl [4];
	logic [2:0] r0;
	logic [2:0] r1;
	logic [3:0] cost0;
	logic [3:0] cost1;
	logic       has0;
	logic       wait0;
	logic       fit0;
	logic       fit1;
	logic       char0;
	logic       char1;
	logic [2:0] used;
	logic [2:0] n1;
	quad_t      w1;
	logic       open_p;
	tok_t       tok;
	logic       emit;
	logic       last;
	logic       close;
	quad_t      a_w;
	logic [2:0] a_n;
	logic       a_cut;
	logic       step;
	logic       fin;
	logic       accept;
	logic       tk_char;

	assign ending = itm_q.cmd;
	assign open_p = !opened_q;

	// append the new text byte behind the held bytes on the first step of an item, unless the string was cut
	always_comb begin
		w_e = w_q;
		n_e = n_q;
		if (!ld_q && !ending && !cut_q) begin
			w_e[n_q[1:0]] = itm_q.text_byte;
			n_e           = n_q + 3'd1;
		end
	end

	// classify at every offset in parallel
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sl[k] = seq_len(quad_t'(w_e >> (8 * k)), (n_e > 3'(k)) ? n_e - 3'(k) : 3'd0,
				ending);
		end
	end

	assign r0    = sl[0];
	assign cost0 = seq_cost(r0);
	assign has0  = (n_e != 3'd0) && !cut_q;
	assign wait0 = r0 == SQ_WAIT;
	assign fit0  = room_q >= $signed(ROOM_W'(cost0));
	assign char0 = has0 && !wait0 && fit0;
	assign used  = (r0 == SQ_BAD) ? 3'd1 : r0;
	assign n1    = n_e - used;
	assign w1    = quad_t'(w_e >> {used, 3'b000});
	assign r1    = sl[used[1:0]];
	assign cost1 = seq_cost(r1);
	assign fit1  = room_q >= $signed(ROOM_W'(cost0 + cost1));
	assign char1 = (n1 != 3'd0) && (r1 != SQ_WAIT) && fit1;

	always_comb begin
		tok      = '0;
		tok.data = w_e;
		tok.len  = r0;
		emit     = 1'b0;
		last     = 1'b1;
		close    = 1'b0;
		a_w      = w_e;
		a_n      = n_e;
		a_cut    = has0 && !wait0;
		if (open_p) begin
			emit     = 1'b1;
			tok.kind = TK_OPEN;
			last     = !(char0 || ending);
		end else if (char0) begin
			emit  = 1'b1;
			last  = !(char1 || ending);
			a_w   = w1;
			a_n   = n1;
			a_cut = (n1 != 3'd0) && (r1 != SQ_WAIT);
			if (r0 == SQ_BAD)
				tok.kind = TK_REPL;
			else if (r0 == SQ_ONE)
				tok.kind = TK_CHAR;
			else
				tok.kind = TK_SEQ;
		end else if (ending) begin
			emit     = 1'b1;
			close    = 1'b1;
			tok.kind = TK_CLOSE;
			tok.cut  = cut_q || has0;
		end
		tok.last = last;
	end

	assign step    = itm_v_q && (!emit || !tq_full);
	assign fin     = step && last;
	assign full    = itm_v_q && !fin;
	assign accept  = push && !full;
	assign tq_push = step && emit;
	assign tq_tok  = tok;
	assign tk_char = step && !open_p && char0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			itm_v_q  <= 1'b0;
			ld_q     <= 1'b0;
			n_q      <= '0;
			opened_q <= 1'b0;
			cut_q    <= 1'b0;
			kept_q   <= '0;
			room_q   <= $signed(ROOM_W'(sat_limit(MAX_KEPT_RST)));
		end else begin
			if (accept)
				itm_v_q <= 1'b1;
			else if (fin)
				itm_v_q <= 1'b0;
			if (step) begin
				ld_q <= !last;
				if (close || (last && a_cut))
					n_q <= '0;
				else
					n_q <= a_n;
				if (close)
					cut_q <= 1'b0;
				else if (last && a_cut)
					cut_q <= 1'b1;
				if (close)
					opened_q <= 1'b0;
				else if (open_p)
					opened_q <= 1'b1;
			end
			if (cfg.wr) begin
				room_q <= $signed(ROOM_W'(cfg.lim)) - $signed(ROOM_W'(kept_q));
			end else if (step && close) begin
				kept_q <= '0;
				room_q <= $signed(ROOM_W'(lim));
			end else if (tk_char) begin
				kept_q <= kept_q + CNT_W'(cost0);
				room_q <= room_q - $signed(ROOM_W'(cost0));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			itm_q <= item;
		if (step)
			w_q <= a_w;
	end

	a_held_max: assert property (@(posedge clk) disable iff (!arst_n)
		!ld_q |-> n_q <= 3'd3)
		else $error("more than three bytes held between items");

	a_cut_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cut_q && !ld_q) |-> n_q == 3'd0)
		else $error("bytes held after the string was cut");

	a_fresh_string: assert property (@(posedge clk) disable iff (!arst_n)
		!opened_q |-> kept_q == '0)
		else $error("kept count nonzero before opening quote");

	a_room_track: assert property (@(posedge clk) disable iff (!arst_n)
		room_q == $signed(ROOM_W'(lim)) - $signed(ROOM_W'(kept_q)))
		else $error("room register out of step with limit and kept count");

endmodule

### design/u8js_back.sv
module u8js_back import u8js_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  tok_t    tok,
	input  logic    tq_empty,
	output logic    tq_pop,
	output result_t result,
	output logic    empty,
	input  logic    pop
);

	logic [2:0] idx_q;
	logic       out_v_q;
	result_t    res_q;
	logic       adv;
	logic       take;
	logic       tail;
	logic [2:0] len;

	assign adv    = !out_v_q || pop;
	assign take   = adv && !tq_empty;
	assign len    = tok_len(tok);
	assign tail   = idx_q == len - 3'd1;
	assign tq_pop = take && tail;
	assign empty  = !out_v_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (take) begin
				out_v_q <= 1'b1;
				idx_q   <= tail ? 3'd0 : idx_q + 3'd1;
			end else if (adv) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.out_byte    <= tok_byte(tok, idx_q);
			res_q.run_last    <= tok.last && tail;
			res_q.string_done <= tok.kind == TK_CLOSE;
			res_q.was_cut     <= (tok.kind == TK_CLOSE) && tok.cut;
		end
	end

endmodule
